>>> rtl/lpmt_pkg.sv
// ----------------------------------------------------------------------------
// lpmt_pkg
// shared types, sizes and codes of the longest prefix match trie unit
// ----------------------------------------------------------------------------
package lpmt_pkg;

   // trie node store
   localparam int NODE_COUNT = 4096;
   localparam int NODE_W     = $clog2(NODE_COUNT);
   localparam int USED_W     = $clog2(NODE_COUNT + 1);

   // forwarding
   localparam int PORT_COUNT = 16;
   localparam int ADDR_W     = 32;
   localparam int LEN_W      = 6;
   localparam int PORT_W     = 4;
   localparam int TTL_W      = 8;
   localparam int STATUS_W   = 3;
   localparam logic [TTL_W-1:0] MIN_TTL = TTL_W'(2);

   // commands
   localparam logic CMD_ADD    = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_STORED  = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_KEPT    = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_FORWARD = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NOROUTE = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_EXPIRED = 3'd5;

   // one trie node, child index 0 means no child
   typedef struct packed {
      logic [NODE_W-1:0] kid1;
      logic [NODE_W-1:0] kid0;
      logic              has_route;
      logic              has_hop;
      logic [ADDR_W-1:0] hop;
      logic [PORT_W-1:0] port;
   } node_type;

   localparam int NODE_BITS = $bits(node_type);

   // deepest route seen on a lookup path
   typedef struct packed {
      logic              found;
      logic              has_hop;
      logic [ADDR_W-1:0] hop;
      logic [PORT_W-1:0] port;
   } route_type;

   // one result item
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PORT_W-1:0]   port;
      logic [ADDR_W-1:0]   hop;
      logic [TTL_W-1:0]    ttl;
   } result_type;

endpackage

>>> rtl/lpmt_ram.sv
// ----------------------------------------------------------------------------
// lpmt_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module lpmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/lpmt_result.sv
// ----------------------------------------------------------------------------
// lpmt_result
// forms the result item from the add status or the best route of a lookup
// ----------------------------------------------------------------------------
module lpmt_result (
   input  logic                             cmd,
   input  logic [lpmt_pkg::STATUS_W-1:0]    add_status,
   input  lpmt_pkg::route_type              best,
   input  logic [lpmt_pkg::ADDR_W-1:0]      dst,
   input  logic [lpmt_pkg::TTL_W-1:0]       ttl_in,
   output lpmt_pkg::result_type             result
);

   logic port_ok;

   assign port_ok = 32'(best.port) < lpmt_pkg::PORT_COUNT;

   always_comb begin
      result = '0;
      if (cmd == lpmt_pkg::CMD_ADD) begin
         result.status = add_status;
      end else if (!best.found || !port_ok) begin
         result.status = lpmt_pkg::STATUS_NOROUTE;
      end else if (ttl_in < lpmt_pkg::MIN_TTL) begin
         result.status = lpmt_pkg::STATUS_EXPIRED;
      end else begin
         result.status = lpmt_pkg::STATUS_FORWARD;
         result.port   = best.port;
         result.hop    = best.has_hop ? best.hop : dst;
         result.ttl    = ttl_in - lpmt_pkg::TTL_W'(1);
      end
   end

endmodule

>>> rtl/ipv4_longest_prefix_match_trie_unit.sv
// ----------------------------------------------------------------------------
// ipv4_longest_prefix_match_trie_unit
// ipv4 route table as a binary trie: route insert and longest prefix lookup
// ----------------------------------------------------------------------------
//
//  channel | ports                                    | direction
//  --------+------------------------------------------+----------
//  req     | cmd address prefix_len hop_given         | in
//          | hop_address port_index ttl_in            |
//  rsp     | status out_port out_hop ttl_out          | out
//
//  one item at a time: the item is accepted, then the walk takes one trie level
//  per cycle, bounded by the single read port of the node ram, then the result
//  is formed; an add writes one node a cycle while new nodes are chained in.
//  the root node sits in flip-flops and is cleared by reset; other nodes are
//  cleared when allocated, so no clearing pass is needed after reset.
//  a result waits in the output register; the next item is taken meanwhile
//  and only its result cycle stalls until rsp_ready.
//
module ipv4_longest_prefix_match_trie_unit (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_cmd,
   input  logic [lpmt_pkg::ADDR_W-1:0]         req_address,
   input  logic [lpmt_pkg::LEN_W-1:0]          req_prefix_len,
   input  logic                                req_hop_given,
   input  logic [lpmt_pkg::ADDR_W-1:0]         req_hop_address,
   input  logic [lpmt_pkg::PORT_W-1:0]         req_port_index,
   input  logic [lpmt_pkg::TTL_W-1:0]          req_ttl_in,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [lpmt_pkg::STATUS_W-1:0]       rsp_status,
   output logic [lpmt_pkg::PORT_W-1:0]         rsp_out_port,
   output logic [lpmt_pkg::ADDR_W-1:0]         rsp_out_hop,
   output logic [lpmt_pkg::TTL_W-1:0]          rsp_ttl_out
);

   // sequencer states
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_WALK  = 2'd1;
   localparam logic [1:0] S_ALLOC = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   localparam int NW = lpmt_pkg::NODE_W;
   localparam int UW = lpmt_pkg::USED_W;

   // sequencer and item registers
   logic [1:0]                        state_ff, state_in;
   logic                              cmd_ff;
   logic [lpmt_pkg::ADDR_W-1:0]       dst_ff;
   logic [lpmt_pkg::ADDR_W-1:0]       path_ff, path_in;
   logic [lpmt_pkg::LEN_W-1:0]        len_ff;
   logic                              hop_given_ff;
   logic [lpmt_pkg::ADDR_W-1:0]       hop_addr_ff;
   logic [lpmt_pkg::PORT_W-1:0]       port_ff;
   logic [lpmt_pkg::TTL_W-1:0]        ttl_ff;
   logic [NW-1:0]                     cur_ff, cur_in;
   logic [lpmt_pkg::LEN_W-1:0]        depth_ff, depth_in;
   logic [UW-1:0]                     used_ff, used_in;
   lpmt_pkg::node_type                root_ff, root_in;
   lpmt_pkg::route_type               best_ff, best_in;
   logic [lpmt_pkg::STATUS_W-1:0]     add_status_ff, add_status_in;

   // output register
   logic                              rsp_valid_ff, rsp_valid_in;
   lpmt_pkg::result_type              rsp_ff, rsp_in;

   // node ram ports
   logic                              ram_wr_en;
   logic [NW-1:0]                     ram_wr_addr;
   lpmt_pkg::node_type                ram_wr_node;
   logic [lpmt_pkg::NODE_BITS-1:0]    ram_rd_data;

   // walk datapath
   lpmt_pkg::node_type                cur_node;
   lpmt_pkg::node_type                parent_node;
   lpmt_pkg::node_type                chain_node;
   lpmt_pkg::node_type                route_node;
   lpmt_pkg::result_type              result;
   logic                              side;
   logic [NW-1:0]                     next_idx;
   logic [NW-1:0]                     new_idx;
   logic [NW-1:0]                     link_idx;
   logic                              store_full;
   logic                              chain_link;
   logic                              at_len;
   logic                              accept;
   logic [lpmt_pkg::LEN_W-1:0]        len_clamped;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);

   // prefix lengths above 32 behave as 32
   assign len_clamped = (req_prefix_len > lpmt_pkg::LEN_W'(lpmt_pkg::ADDR_W))
                        ? lpmt_pkg::LEN_W'(lpmt_pkg::ADDR_W) : req_prefix_len;

   // node under the walk: root from flops, others from last ram read
   assign cur_node = (cur_ff == '0) ? root_ff : lpmt_pkg::node_type'(ram_rd_data);
   assign side     = path_ff[lpmt_pkg::ADDR_W-1];
   assign next_idx = side ? cur_node.kid1 : cur_node.kid0;
   assign at_len   = (depth_ff == len_ff);

   assign new_idx    = used_ff[NW-1:0];
   assign link_idx   = NW'(used_ff + UW'(1));
   assign store_full = (used_ff == UW'(lpmt_pkg::NODE_COUNT));
   // a fresh node links to the next fresh node only if one can be allocated
   assign chain_link = !at_len && (used_ff < UW'(lpmt_pkg::NODE_COUNT - 1));

   // current node with the item's route written in
   always_comb begin
      route_node           = cur_node;
      route_node.has_route = 1'b1;
      route_node.has_hop   = hop_given_ff;
      route_node.hop       = hop_addr_ff;
      route_node.port      = port_ff;
   end

   // parent gets a link to the first newly allocated node
   always_comb begin
      parent_node = cur_node;
      if (side) begin
         parent_node.kid1 = new_idx;
      end else begin
         parent_node.kid0 = new_idx;
      end
   end

   // freshly allocated node on a chain, route only at the last level
   always_comb begin
      chain_node = '0;
      if (chain_link) begin
         if (side) begin
            chain_node.kid1 = link_idx;
         end else begin
            chain_node.kid0 = link_idx;
         end
      end
      if (at_len) begin
         chain_node.has_route = 1'b1;
         chain_node.has_hop   = hop_given_ff;
         chain_node.hop       = hop_addr_ff;
         chain_node.port      = port_ff;
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      path_in       = path_ff;
      cur_in        = cur_ff;
      depth_in      = depth_ff;
      used_in       = used_ff;
      root_in       = root_ff;
      best_in       = best_ff;
      add_status_in = add_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = cur_ff;
      ram_wr_node   = route_node;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_WALK;
               path_in  = req_address;
               cur_in   = '0;
               depth_in = '0;
               best_in  = '0;
            end
         end

         S_WALK: begin
            if (cmd_ff == lpmt_pkg::CMD_LOOKUP) begin
               // remember the deepest node holding a route
               if (cur_node.has_route) begin
                  best_in.found   = 1'b1;
                  best_in.has_hop = cur_node.has_hop;
                  best_in.hop     = cur_node.hop;
                  best_in.port    = cur_node.port;
               end
               if (depth_ff == lpmt_pkg::LEN_W'(lpmt_pkg::ADDR_W) || next_idx == '0) begin
                  state_in = S_DONE;
               end else begin
                  cur_in   = next_idx;
                  depth_in = depth_ff + lpmt_pkg::LEN_W'(1);
                  path_in  = path_ff << 1;
               end
            end else begin
               priority if (at_len) begin
                  // zero length always overwrites the default route
                  if (cur_node.has_route && len_ff != '0) begin
                     add_status_in = lpmt_pkg::STATUS_KEPT;
                  end else begin
                     add_status_in = lpmt_pkg::STATUS_STORED;
                     if (cur_ff == '0) begin
                        root_in = route_node;
                     end else begin
                        ram_wr_en = 1'b1;
                     end
                  end
                  state_in = S_DONE;
               end else if (next_idx != '0) begin
                  cur_in   = next_idx;
                  depth_in = depth_ff + lpmt_pkg::LEN_W'(1);
                  path_in  = path_ff << 1;
               end else if (store_full) begin
                  add_status_in = lpmt_pkg::STATUS_FULL;
                  state_in      = S_DONE;
               end else begin
                  // link the parent, then build the rest of the path
                  if (cur_ff == '0) begin
                     root_in = parent_node;
                  end else begin
                     ram_wr_en   = 1'b1;
                     ram_wr_node = parent_node;
                  end
                  depth_in = depth_ff + lpmt_pkg::LEN_W'(1);
                  path_in  = path_ff << 1;
                  state_in = S_ALLOC;
               end
            end
         end

         S_ALLOC: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = new_idx;
            ram_wr_node = chain_node;
            used_in     = used_ff + UW'(1);
            depth_in    = depth_ff + lpmt_pkg::LEN_W'(1);
            path_in     = path_ff << 1;
            if (at_len) begin
               add_status_in = lpmt_pkg::STATUS_STORED;
               state_in      = S_DONE;
            end else if (!chain_link) begin
               add_status_in = lpmt_pkg::STATUS_FULL;
               state_in      = S_DONE;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = result;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= UW'(1);
         root_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         root_ff      <= root_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // item and walk registers
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff       <= req_cmd;
         dst_ff       <= req_address;
         len_ff       <= len_clamped;
         hop_given_ff <= req_hop_given;
         hop_addr_ff  <= req_hop_address;
         port_ff      <= req_port_index;
         ttl_ff       <= req_ttl_in;
      end
      path_ff       <= path_in;
      cur_ff        <= cur_in;
      depth_ff      <= depth_in;
      best_ff       <= best_in;
      add_status_ff <= add_status_in;
      rsp_ff        <= rsp_in;
   end

   // node store
   lpmt_ram #(
      .WIDTH (lpmt_pkg::NODE_BITS),
      .DEPTH (lpmt_pkg::NODE_COUNT)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_node),
      .rd_en   (state_ff == S_WALK),
      .rd_addr (next_idx),
      .rd_data (ram_rd_data)
   );

   // result forming
   lpmt_result u_result (
      .cmd        (cmd_ff),
      .add_status (add_status_ff),
      .best       (best_ff),
      .dst        (dst_ff),
      .ttl_in     (ttl_ff),
      .result     (result)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_ff.status;
   assign rsp_out_port = rsp_ff.port;
   assign rsp_out_hop  = rsp_ff.hop;
   assign rsp_ttl_out  = rsp_ff.ttl;

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench for ipv4_longest_prefix_match_trie_unit
// drives route inserts and datagram lookups over the req channel, predicts
// every rsp item with an independent trie model and checks each field in
// order; directed corner cases first, then shaped random traffic under
// changing backpressure, then a run that fills the node store
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #10 clock = ~clock;

   // request channel
   logic                          req_valid       = 1'b0;
   logic                          req_ready;
   logic                          req_cmd         = lpmt_pkg::CMD_ADD;
   logic [lpmt_pkg::ADDR_W-1:0]   req_address     = '0;
   logic [lpmt_pkg::LEN_W-1:0]    req_prefix_len  = '0;
   logic                          req_hop_given   = 1'b0;
   logic [lpmt_pkg::ADDR_W-1:0]   req_hop_address = '0;
   logic [lpmt_pkg::PORT_W-1:0]   req_port_index  = '0;
   logic [lpmt_pkg::TTL_W-1:0]    req_ttl_in      = '0;

   // response channel
   logic                          rsp_valid;
   logic                          rsp_ready       = 1'b0;
   logic [lpmt_pkg::STATUS_W-1:0] rsp_status;
   logic [lpmt_pkg::PORT_W-1:0]   rsp_out_port;
   logic [lpmt_pkg::ADDR_W-1:0]   rsp_out_hop;
   logic [lpmt_pkg::TTL_W-1:0]    rsp_ttl_out;

   ipv4_longest_prefix_match_trie_unit uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_address     (req_address),
      .req_prefix_len  (req_prefix_len),
      .req_hop_given   (req_hop_given),
      .req_hop_address (req_hop_address),
      .req_port_index  (req_port_index),
      .req_ttl_in      (req_ttl_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_out_port    (rsp_out_port),
      .rsp_out_hop     (rsp_out_hop),
      .rsp_ttl_out     (rsp_ttl_out)
   );

   // ------------------------------------------------------------------------
   // trie model: own copy of the node store
   // ------------------------------------------------------------------------
   int unsigned                 node_kid0    [lpmt_pkg::NODE_COUNT];
   int unsigned                 node_kid1    [lpmt_pkg::NODE_COUNT];
   bit                          node_routed  [lpmt_pkg::NODE_COUNT];
   bit                          node_has_hop [lpmt_pkg::NODE_COUNT];
   logic [lpmt_pkg::ADDR_W-1:0] node_hop     [lpmt_pkg::NODE_COUNT];
   logic [lpmt_pkg::PORT_W-1:0] node_port    [lpmt_pkg::NODE_COUNT];
   int unsigned                 nodes_taken;

   // results still owed by the unit, oldest first
   lpmt_pkg::result_type pending_results [$];

   // known prefixes, steer lookups and re-inserts onto real paths
   logic [lpmt_pkg::ADDR_W-1:0] known_prefix [$];
   int unsigned                 known_len    [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count   = 0;
   int items_sent    = 0;
   int full_predicted = 0;
   int status_count [8];

   lpmt_pkg::result_type got_result;
   lpmt_pkg::result_type want_result;

   function automatic void place_route(input int unsigned idx, input logic hop_given,
                                       input logic [lpmt_pkg::ADDR_W-1:0] hop,
                                       input logic [lpmt_pkg::PORT_W-1:0] port);
      node_routed[idx]  = 1'b1;
      node_has_hop[idx] = hop_given;
      node_hop[idx]     = hop;
      node_port[idx]    = port;
   endfunction

   // add route: walk prefix bits from the top, chain in missing nodes
   function automatic lpmt_pkg::result_type route_insert(
         input logic [lpmt_pkg::ADDR_W-1:0] prefix,
         input logic [lpmt_pkg::LEN_W-1:0]  len_in,
         input logic                        hop_given,
         input logic [lpmt_pkg::ADDR_W-1:0] hop,
         input logic [lpmt_pkg::PORT_W-1:0] port);
      lpmt_pkg::result_type res;
      int unsigned len;
      int unsigned cur;
      int unsigned nxt;
      int          i;
      logic        side;
      res = '0;
      len = (len_in > 32) ? 32 : len_in;
      // default route is always overwritten
      if (len == 0) begin
         place_route(0, hop_given, hop, port);
         res.status = lpmt_pkg::STATUS_STORED;
         return res;
      end
      cur = 0;
      for (i = 0; i < len; i++) begin
         side = prefix[lpmt_pkg::ADDR_W-1-i];
         nxt  = side ? node_kid1[cur] : node_kid0[cur];
         if (nxt == 0) begin
            // store full: nodes chained so far stay without a route
            if (nodes_taken >= lpmt_pkg::NODE_COUNT) begin
               res.status = lpmt_pkg::STATUS_FULL;
               return res;
            end
            nxt = nodes_taken;
            nodes_taken++;
            node_kid0[nxt]    = 0;
            node_kid1[nxt]    = 0;
            node_routed[nxt]  = 1'b0;
            node_has_hop[nxt] = 1'b0;
            node_hop[nxt]     = '0;
            node_port[nxt]    = '0;
            if (side)
               node_kid1[cur] = nxt;
            else
               node_kid0[cur] = nxt;
         end
         cur = nxt;
      end
      // first route on a node wins
      if (node_routed[cur]) begin
         res.status = lpmt_pkg::STATUS_KEPT;
      end else begin
         place_route(cur, hop_given, hop, port);
         res.status = lpmt_pkg::STATUS_STORED;
      end
      return res;
   endfunction

   // lookup: deepest routed node on the destination path
   function automatic lpmt_pkg::result_type route_lookup(
         input logic [lpmt_pkg::ADDR_W-1:0] dst,
         input logic [lpmt_pkg::TTL_W-1:0]  ttl_in);
      lpmt_pkg::result_type res;
      int unsigned cur;
      int unsigned nxt;
      int unsigned best;
      int          depth;
      bit          found;
      bit          walking;
      res     = '0;
      found   = node_routed[0];
      best    = 0;
      cur     = 0;
      walking = 1'b1;
      for (depth = 0; depth < lpmt_pkg::ADDR_W && walking; depth++) begin
         nxt = dst[lpmt_pkg::ADDR_W-1-depth] ? node_kid1[cur] : node_kid0[cur];
         if (nxt == 0) begin
            walking = 1'b0;
         end else begin
            if (node_routed[nxt]) begin
               found = 1'b1;
               best  = nxt;
            end
            cur = nxt;
         end
      end
      if (!found || node_port[best] >= lpmt_pkg::PORT_COUNT) begin
         res.status = lpmt_pkg::STATUS_NOROUTE;
      end else if (ttl_in < lpmt_pkg::MIN_TTL) begin
         res.status = lpmt_pkg::STATUS_EXPIRED;
      end else begin
         res.status = lpmt_pkg::STATUS_FORWARD;
         res.port   = node_port[best];
         res.hop    = node_has_hop[best] ? node_hop[best] : dst;
         res.ttl    = ttl_in - lpmt_pkg::TTL_W'(1);
      end
      return res;
   endfunction

   function automatic logic [lpmt_pkg::ADDR_W-1:0] host_bits(input int unsigned len);
      return (len >= 32) ? '0 : (32'hFFFF_FFFF >> len);
   endfunction

   // ------------------------------------------------------------------------
   // receiver: random backpressure on rsp_ready
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // ------------------------------------------------------------------------
   // checker: each accepted rsp item against the oldest expectation
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_result = {rsp_status, rsp_out_port, rsp_out_hop, rsp_ttl_out};
         status_count[rsp_status]++;
         if (pending_results.size() == 0) begin
            error_count++;
            $display("%0t: unexpected rsp item, expected none, actual %h", $time,
                     got_result);
         end else begin
            want_result = pending_results.pop_front();
            if (rsp_status !== want_result.status) begin
               error_count++;
               $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                        want_result.status, rsp_status);
            end
            if (rsp_out_port !== want_result.port) begin
               error_count++;
               $display("%0t: out_port mismatch, expected %0d, actual %0d", $time,
                        want_result.port, rsp_out_port);
            end
            if (rsp_out_hop !== want_result.hop) begin
               error_count++;
               $display("%0t: out_hop mismatch, expected %h, actual %h", $time,
                        want_result.hop, rsp_out_hop);
            end
            if (rsp_ttl_out !== want_result.ttl) begin
               error_count++;
               $display("%0t: ttl_out mismatch, expected %0d, actual %0d", $time,
                        want_result.ttl, rsp_ttl_out);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // sender: one item, idle cycles in front of it at the set rate
   // ------------------------------------------------------------------------
   task automatic send_request(input logic cmd, input logic [lpmt_pkg::ADDR_W-1:0] addr,
                               input logic [lpmt_pkg::LEN_W-1:0] plen,
                               input logic hop_given,
                               input logic [lpmt_pkg::ADDR_W-1:0] hop,
                               input logic [lpmt_pkg::PORT_W-1:0] port,
                               input logic [lpmt_pkg::TTL_W-1:0] ttl);
      lpmt_pkg::result_type res;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_address     <= addr;
      req_prefix_len  <= plen;
      req_hop_given   <= hop_given;
      req_hop_address <= hop;
      req_port_index  <= port;
      req_ttl_in      <= ttl;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // accepted at this edge
      if (cmd == lpmt_pkg::CMD_ADD)
         res = route_insert(addr, plen, hop_given, hop, port);
      else
         res = route_lookup(addr, ttl);
      if (res.status == lpmt_pkg::STATUS_FULL)
         full_predicted++;
      pending_results.insert(pending_results.size(), res);
      items_sent++;
   endtask

   task automatic insert_route(input logic [lpmt_pkg::ADDR_W-1:0] addr,
                               input logic [lpmt_pkg::LEN_W-1:0] plen,
                               input logic hop_given,
                               input logic [lpmt_pkg::ADDR_W-1:0] hop,
                               input logic [lpmt_pkg::PORT_W-1:0] port);
      send_request(lpmt_pkg::CMD_ADD, addr, plen, hop_given, hop, port,
                   lpmt_pkg::TTL_W'($urandom()));
   endtask

   task automatic look_up(input logic [lpmt_pkg::ADDR_W-1:0] dst,
                          input logic [lpmt_pkg::TTL_W-1:0] ttl);
      send_request(lpmt_pkg::CMD_LOOKUP, dst, lpmt_pkg::LEN_W'($urandom()), 1'($urandom()),
                   $urandom(), lpmt_pkg::PORT_W'($urandom()), ttl);
   endtask

   // hold the sender off until the unit has answered everything
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // directed tests
   // ------------------------------------------------------------------------
   task automatic test_empty_table();
      // no route anywhere, not even a default, wins over a short ttl
      look_up(32'hC0A8_0101, 8'd64);
      look_up(32'h0000_0000, 8'd0);
   endtask

   task automatic test_default_route();
      insert_route(32'h1234_5678, 6'd0, 1'b1, 32'h0A00_0001, 4'd7);
      look_up(32'hDEAD_BEEF, 8'd255);
      // zero length overwrites, now directly attached
      insert_route(32'h0000_0000, 6'd0, 1'b0, 32'hFFFF_FFFF, 4'd15);
      look_up(32'h8000_0000, 8'd2);
   endtask

   task automatic test_first_route_wins();
      insert_route(32'h0A00_0000, 6'd8, 1'b1, 32'hAC10_0001, 4'd3);
      insert_route(32'h0AFF_FFFF, 6'd8, 1'b0, 32'h0000_0000, 4'd9);
      insert_route(32'h0A01_0000, 6'd16, 1'b0, 32'h0505_0505, 4'd1);
      look_up(32'h0A01_0203, 8'd100);
      look_up(32'h0A02_0304, 8'd100);
   endtask

   task automatic test_prefix_extremes();
      insert_route(32'hFFFF_FFFF, 6'd32, 1'b1, 32'hFFFF_FFFF, 4'd15);
      insert_route(32'h0000_0000, 6'd1, 1'b1, 32'h0000_0000, 4'd0);
      // lengths beyond 32 clamp to a host route
      insert_route(32'h0000_0001, 6'd33, 1'b1, 32'h5555_AAAA, 4'd5);
      insert_route(32'h0000_0001, 6'd63, 1'b0, 32'hAAAA_5555, 4'd6);
      look_up(32'hFFFF_FFFF, 8'd255);
      look_up(32'h0000_0000, 8'd10);
   endtask

   task automatic test_ttl_edges();
      look_up(32'h0A00_0009, 8'd0);
      look_up(32'h0A00_0009, 8'd1);
      look_up(32'h0A00_0009, 8'd2);
      look_up(32'h0000_0001, 8'd255);
   endtask

   // ------------------------------------------------------------------------
   // random traffic: lookups mostly onto known prefixes, inserts that share
   // paths, re-inserts of existing prefixes and some default routes
   // ------------------------------------------------------------------------
   task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
      logic [lpmt_pkg::ADDR_W-1:0] addr;
      logic [lpmt_pkg::LEN_W-1:0]  plen;
      logic [lpmt_pkg::TTL_W-1:0]  ttl;
      int unsigned                 pick;
      int unsigned                 kind;
      int                          n;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (n = 0; n < count; n++) begin
         addr = $urandom();
         plen = lpmt_pkg::LEN_W'($urandom());
         ttl  = lpmt_pkg::TTL_W'($urandom());
         kind = $urandom_range(0, 99);
         if (kind < 60) begin
            if (known_prefix.size() > 0 && $urandom_range(0, 9) < 8) begin
               pick = $urandom_range(0, known_prefix.size() - 1);
               addr = known_prefix[pick] ^ ($urandom() & host_bits(known_len[pick]));
            end
            if ($urandom_range(0, 9) == 0)
               ttl = lpmt_pkg::TTL_W'($urandom_range(0, 1));
            send_request(lpmt_pkg::CMD_LOOKUP, addr, plen, 1'($urandom()), $urandom(),
                         lpmt_pkg::PORT_W'($urandom()), ttl);
         end else if (kind < 66 && known_prefix.size() > 0) begin
            // same prefix again, host bits may differ
            pick = $urandom_range(0, known_prefix.size() - 1);
            addr = known_prefix[pick] ^ ($urandom() & host_bits(known_len[pick]));
            send_request(lpmt_pkg::CMD_ADD, addr, lpmt_pkg::LEN_W'(known_len[pick]),
                         1'($urandom()), $urandom(), lpmt_pkg::PORT_W'($urandom()), ttl);
         end else if (kind < 68) begin
            send_request(lpmt_pkg::CMD_ADD, addr, 6'd0, 1'($urandom()), $urandom(),
                         lpmt_pkg::PORT_W'($urandom()), ttl);
         end else begin
            case ($urandom_range(0, 9))
               0:       plen = lpmt_pkg::LEN_W'($urandom_range(1, 7));
               7, 8:    plen = lpmt_pkg::LEN_W'($urandom_range(25, 32));
               9:       plen = lpmt_pkg::LEN_W'($urandom_range(33, 63));
               default: plen = lpmt_pkg::LEN_W'($urandom_range(8, 24));
            endcase
            // extend an existing prefix half of the time
            if (known_prefix.size() > 0 && $urandom_range(0, 1) == 1) begin
               pick = $urandom_range(0, known_prefix.size() - 1);
               addr = known_prefix[pick] ^ ($urandom() & host_bits(known_len[pick]));
            end
            known_prefix.insert(known_prefix.size(), addr);
            known_len.insert(known_len.size(), 32'(plen));
            send_request(lpmt_pkg::CMD_ADD, addr, plen, 1'($urandom()), $urandom(),
                         lpmt_pkg::PORT_W'($urandom()), ttl);
         end
      end
   endtask

   // host routes on fresh addresses until the store has refused several
   task automatic test_table_full();
      logic [lpmt_pkg::ADDR_W-1:0] addr;
      int unsigned                 pick;
      int                          n;
      int                          full_goal;
      send_idle_pct = 25;
      recv_idle_pct = 25;
      full_goal = full_predicted + 24;
      for (n = 0; n < 800 && full_predicted < full_goal; n++) begin
         addr = $urandom();
         if ($urandom_range(0, 3) != 0) begin
            insert_route(addr, lpmt_pkg::LEN_W'($urandom_range(32, 40)), 1'($urandom()),
                         $urandom(), lpmt_pkg::PORT_W'($urandom()));
         end else begin
            if (known_prefix.size() > 0) begin
               pick = $urandom_range(0, known_prefix.size() - 1);
               addr = known_prefix[pick] ^ ($urandom() & host_bits(known_len[pick]));
            end
            look_up(addr, lpmt_pkg::TTL_W'($urandom()));
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      foreach (status_count[i]) status_count[i] = 0;
      node_kid0[0]    = 0;
      node_kid1[0]    = 0;
      node_routed[0]  = 1'b0;
      node_has_hop[0] = 1'b0;
      node_hop[0]     = '0;
      node_port[0]    = '0;
      nodes_taken     = 1;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 25;
      recv_idle_pct = 55;
      test_empty_table();
      test_default_route();
      test_first_route_wins();
      test_prefix_extremes();
      test_ttl_edges();
      wait_results_drained();

      test_random_traffic(600, 25, 55);
      wait_results_drained();
      test_random_traffic(600, 55, 25);
      wait_results_drained();
      test_random_traffic(600, 0, 0);
      wait_results_drained();
      test_table_full();
      wait_results_drained();

      $display("covered %0d items, %0d trie nodes in use at the end", items_sent, nodes_taken);
      $display("stored %0d kept %0d full %0d forward %0d no route %0d expired %0d",
               status_count[lpmt_pkg::STATUS_STORED], status_count[lpmt_pkg::STATUS_KEPT],
               status_count[lpmt_pkg::STATUS_FULL], status_count[lpmt_pkg::STATUS_FORWARD],
               status_count[lpmt_pkg::STATUS_NOROUTE],
               status_count[lpmt_pkg::STATUS_EXPIRED]);
      if (pending_results.size() != 0) begin
         error_count++;
         $display("%0t: %0d results never arrived", $time, pending_results.size());
      end
      if (error_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   // watchdog
   initial begin
      #40_000_000;
      $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
      $display("testbench NOT OK");
      $finish;
   end

endmodule
